>>> sv/mesi_snoop_line_controller_unit_defines.svh
// Assertion macros shared by the coherence controller RTL.
`ifndef MESI_SNOOP_LINE_CONTROLLER_UNIT_DEFINES_SVH
`define MESI_SNOOP_LINE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MSCU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication: the consequence is checked after the antecedent.
`define MSCU_ASSERT_DLY2(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

>>> sv/mscu_pkg.sv
// Types and codes of the MESI snooping line controller.
`default_nettype none

package mscu_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned IDX_EXT_W = 16;

  typedef enum logic [STATE_W-1:0] {
    ST_I  = 3'd0,
    ST_S  = 3'd1,
    ST_E  = 3'd2,
    ST_M  = 3'd3,
    ST_IS = 3'd4,
    ST_IM = 3'd5,
    ST_SM = 3'd6
  } state_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 3'd0,
    CMD_STORE = 3'd1,
    CMD_GETS  = 3'd2,
    CMD_GETM  = 3'd3,
    CMD_DATA  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_PROC = 3'd1,
    ACT_GETS = 3'd2,
    ACT_GETM = 3'd3,
    ACT_BUS  = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_OUTSTANDING = 2'd1,
    ERR_HELD_DATA   = 2'd2
  } err_e;

  typedef struct packed {
    act_e              action;
    logic              assert_shared;
    logic [ADDR_W-1:0] out_address;
    logic [ID_W-1:0]   dest_id;
    state_e            new_state;
    logic              miss;
    logic              peer_fill;
    err_e              error_code;
  } resp_t;

endpackage

`default_nettype wire

>>> sv/mscu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mscu_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/mscu_xition.sv
// Coherence transition logic: one event against one line state.
`default_nettype none

module mscu_xition (
  input  wire logic [mscu_pkg::CMD_W-1:0]  cmd_i,
  input  wire mscu_pkg::state_e            state_i,
  input  wire logic [mscu_pkg::ADDR_W-1:0] address_i,
  input  wire logic [mscu_pkg::ID_W-1:0]   source_id_i,
  input  wire logic                        shared_seen_i,
  input  wire logic                        in_range_i,
  output mscu_pkg::resp_t                  resp_o
);

  import mscu_pkg::*;

  act_e   act;
  logic   ash;
  logic   miss;
  logic   fill;
  err_e   err;
  state_e ns;

  // Decode the event against the current state
  always_comb begin
    act  = ACT_NONE;
    ash  = 1'b0;
    miss = 1'b0;
    fill = 1'b0;
    err  = ERR_NONE;
    ns   = state_i;
    unique case (cmd_i)
      CMD_LOAD, CMD_STORE: begin
        unique case (state_i)
          ST_I: begin
            act  = (cmd_i == CMD_STORE) ? ACT_GETM : ACT_GETS;
            ns   = (cmd_i == CMD_STORE) ? ST_IM : ST_IS;
            miss = 1'b1;
          end
          ST_S: begin
            if (cmd_i == CMD_STORE) begin
              act = ACT_GETM;
              ns  = ST_SM;
            end else begin
              act = ACT_PROC;
            end
          end
          ST_E: begin
            act = ACT_PROC;
            if (cmd_i == CMD_STORE) begin
              ns = ST_M;
            end
          end
          ST_M: begin
            act = ACT_PROC;
          end
          default: begin
            err = ERR_OUTSTANDING;
          end
        endcase
      end
      CMD_GETS, CMD_GETM: begin
        unique case (state_i)
          ST_S: begin
            if (cmd_i == CMD_GETM) begin
              ns = ST_I;
            end else begin
              act = ACT_BUS;
              ash = 1'b1;
            end
          end
          ST_E: begin
            act = ACT_BUS;
            ash = 1'b1;
            ns  = (cmd_i == CMD_GETM) ? ST_I : ST_S;
          end
          ST_M: begin
            act = ACT_BUS;
            ash = 1'b1;
            ns  = ST_I;
          end
          default: begin
          end
        endcase
      end
      CMD_DATA: begin
        unique case (state_i)
          ST_S, ST_E, ST_M: begin
            err = ERR_HELD_DATA;
          end
          ST_IS: begin
            act  = ACT_PROC;
            fill = shared_seen_i;
            ns   = shared_seen_i ? ST_S : ST_E;
          end
          ST_IM: begin
            act  = ACT_PROC;
            fill = shared_seen_i;
            ns   = ST_M;
          end
          ST_SM: begin
            act = ACT_PROC;
            ns  = ST_M;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Assemble the result; zero it for a line outside the store
  always_comb begin
    resp_o = '0;
    if (in_range_i) begin
      resp_o.action        = act;
      resp_o.assert_shared = ash;
      resp_o.out_address   = (act != ACT_NONE) ? address_i : '0;
      resp_o.dest_id       = (act == ACT_BUS) ? source_id_i : '0;
      resp_o.new_state     = ns;
      resp_o.miss          = miss;
      resp_o.peer_fill     = fill;
      resp_o.error_code    = err;
    end
  end

endmodule

`default_nettype wire

>>> sv/mesi_snoop_line_controller_unit.sv
// Top level of the MESI snooping line controller.
//
//  port group    direction  handshake             contents
//  event in      input      start & !busy         command, line, address, source, shared
//  result out    output     done (one cycle)      action, shared, address, dest, state, flags
//
// One event is taken per cycle while busy is low; its result passes the input
// register and the result register and strobes on done. The state store is a
// RAM with a registered read; a write from the previous event to the same line
// is forwarded around the RAM. Busy stays high after reset while the store is swept to I.
// Results cannot be stalled: each one is shown for exactly one cycle.
`default_nettype none
`include "mesi_snoop_line_controller_unit_defines.svh"

module mesi_snoop_line_controller_unit #(
  parameter int unsigned LINES = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [mscu_pkg::CMD_W-1:0]  command_i,
  input  wire logic [mscu_pkg::IDX_W-1:0]  line_index_i,
  input  wire logic [mscu_pkg::ADDR_W-1:0] address_i,
  input  wire logic [mscu_pkg::ID_W-1:0]   source_id_i,
  input  wire logic                        shared_seen_i,
  output logic                             done_o,
  output logic [2:0]                       action_o,
  output logic                             assert_shared_o,
  output logic [mscu_pkg::ADDR_W-1:0]      out_address_o,
  output logic [mscu_pkg::ID_W-1:0]        dest_id_o,
  output logic [mscu_pkg::STATE_W-1:0]     new_state_o,
  output logic                             miss_o,
  output logic                             peer_fill_o,
  output logic [1:0]                       error_code_o
);

  import mscu_pkg::*;

  localparam int unsigned AW = (LINES > 1) ? $clog2(LINES) : 1;

  logic                 accept;
  logic [IDX_EXT_W-1:0] idx_in_ext;
  logic [IDX_EXT_W-1:0] idx_s1_ext;

  logic                 clr_active_q;
  logic [AW-1:0]        clr_cnt_q;

  logic                 s1_valid_q;
  logic [CMD_W-1:0]     s1_cmd_q;
  logic [IDX_W-1:0]     s1_idx_q;
  logic [ADDR_W-1:0]    s1_addr_q;
  logic [ID_W-1:0]      s1_src_q;
  logic                 s1_shared_q;
  logic                 s1_in_range;

  logic                 fwd_q;
  state_e               fwd_state_q;

  logic [STATE_W-1:0]   ram_rdata;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [STATE_W-1:0]   ram_wdata;
  state_e               cur_state;

  resp_t                resp;
  resp_t                resp_q;
  logic                 done_q;

  assign busy       = clr_active_q;
  assign accept     = start && !clr_active_q;
  assign idx_in_ext = IDX_EXT_W'(line_index_i);
  assign idx_s1_ext = IDX_EXT_W'(s1_idx_q);
  assign s1_in_range = (32'(s1_idx_q) < LINES);

  // Sweep the state store to I after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      if (clr_cnt_q == AW'(LINES - 1)) begin
        clr_active_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Input register: hold the event while its state is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q    <= command_i;
      s1_idx_q    <= line_index_i;
      s1_addr_q   <= address_i;
      s1_src_q    <= source_id_i;
      s1_shared_q <= shared_seen_i;
    end
    // forward the state written this cycle to an event on the same line
    fwd_q       <= s1_valid_q && s1_in_range && (s1_idx_q == line_index_i);
    fwd_state_q <= resp.new_state;
  end

  // State store write: sweep first, then the updated line
  always_comb begin
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = ST_I;
    end else begin
      ram_we    = s1_valid_q && s1_in_range;
      ram_waddr = idx_s1_ext[AW-1:0];
      ram_wdata = resp.new_state;
    end
  end

  mscu_ram #(
    .WIDTH (STATE_W),
    .DEPTH (LINES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_in_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign cur_state = fwd_q ? fwd_state_q : state_e'(ram_rdata);

  mscu_xition u_xition (
    .cmd_i         (s1_cmd_q),
    .state_i       (cur_state),
    .address_i     (s1_addr_q),
    .source_id_i   (s1_src_q),
    .shared_seen_i (s1_shared_q),
    .in_range_i    (s1_in_range),
    .resp_o        (resp)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      resp_q <= resp;
    end
  end

  assign done_o          = done_q;
  assign action_o        = resp_q.action;
  assign assert_shared_o = resp_q.assert_shared;
  assign out_address_o   = resp_q.out_address;
  assign dest_id_o       = resp_q.dest_id;
  assign new_state_o     = resp_q.new_state;
  assign miss_o          = resp_q.miss;
  assign peer_fill_o     = resp_q.peer_fill;
  assign error_code_o    = resp_q.error_code;

  // Checks
  `MSCU_ASSERT_DLY2(a_result_follows, clk_i, rst_ni, accept, done_o, "transfer without result")
  `MSCU_ASSERT_NOW(a_no_result_in_sweep, clk_i, rst_ni, busy, !done_o, "result during sweep")
  `MSCU_ASSERT_NOW(a_dest_only_on_bus, clk_i, rst_ni,
                   done_o && (dest_id_o != '0), action_o == ACT_BUS,
                   "dest without bus data")
  `MSCU_ASSERT_NOW(a_outstanding_transient, clk_i, rst_ni,
                   done_o && (error_code_o == ERR_OUTSTANDING),
                   (new_state_o == ST_IS) || (new_state_o == ST_IM) || (new_state_o == ST_SM),
                   "outstanding error in stable state")

endmodule

`default_nettype wire

>>> test/tb_mesi_snoop_line_controller_unit.sv
// Testbench for the MESI snooping line controller: directed protocol walks and random traffic.
`timescale 1ns / 100ps

module tb_mesi_snoop_line_controller_unit;
  import mscu_pkg::*;

  localparam int unsigned LINES     = 1024;
  localparam int unsigned HOT_LINES = 12;
  localparam int unsigned IDLE_PCT  = 26;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    command_i;
  logic [IDX_W-1:0]    line_index_i;
  logic [ADDR_W-1:0]   address_i;
  logic [ID_W-1:0]     source_id_i;
  logic                shared_seen_i;
  logic                done_o;
  logic [2:0]          action_o;
  logic                assert_shared_o;
  logic [ADDR_W-1:0]   out_address_o;
  logic [ID_W-1:0]     dest_id_o;
  logic [STATE_W-1:0]  new_state_o;
  logic                miss_o;
  logic                peer_fill_o;
  logic [1:0]          error_code_o;

  // Coherence state per line as the testbench sees it, and responses still to come
  state_e              line_model [LINES];
  resp_t               pending_responses [$];
  logic [IDX_W-1:0]    hot_lines [HOT_LINES];
  bit                  idling_on;
  int                  error_count;
  int                  sent_count;
  int                  checked_count;
  int                  miss_count;
  int                  fill_count;
  int                  bus_count;
  int                  protocol_err_count;

  mesi_snoop_line_controller_unit #(
    .LINES(LINES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .line_index_i   (line_index_i),
    .address_i      (address_i),
    .source_id_i    (source_id_i),
    .shared_seen_i  (shared_seen_i),
    .done_o         (done_o),
    .action_o       (action_o),
    .assert_shared_o(assert_shared_o),
    .out_address_o  (out_address_o),
    .dest_id_o      (dest_id_o),
    .new_state_o    (new_state_o),
    .miss_o         (miss_o),
    .peer_fill_o    (peer_fill_o),
    .error_code_o   (error_code_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one event to the tracked line state and return the response it produces
  function automatic resp_t next_line_response(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                               logic [ADDR_W-1:0] addr, logic [ID_W-1:0] src,
                                               logic shared);
    state_e cur;
    resp_t  r;
    cur          = line_model[idx];
    r            = '0;
    r.action     = ACT_NONE;
    r.error_code = ERR_NONE;
    r.new_state  = cur;
    case (cmd)
      CMD_LOAD, CMD_STORE: begin
        case (cur)
          ST_I: begin
            r.miss = 1'b1;
            if (cmd == CMD_STORE) begin
              r.action    = ACT_GETM;
              r.new_state = ST_IM;
            end else begin
              r.action    = ACT_GETS;
              r.new_state = ST_IS;
            end
          end
          ST_S: begin
            if (cmd == CMD_STORE) begin
              r.action    = ACT_GETM;
              r.new_state = ST_SM;
            end else begin
              r.action = ACT_PROC;
            end
          end
          ST_E: begin
            r.action = ACT_PROC;
            if (cmd == CMD_STORE) r.new_state = ST_M;
          end
          ST_M: r.action = ACT_PROC;
          default: r.error_code = ERR_OUTSTANDING;
        endcase
      end
      CMD_GETS, CMD_GETM: begin
        case (cur)
          ST_S: begin
            if (cmd == CMD_GETM) begin
              r.new_state = ST_I;
            end else begin
              r.action        = ACT_BUS;
              r.assert_shared = 1'b1;
            end
          end
          ST_E: begin
            r.action        = ACT_BUS;
            r.assert_shared = 1'b1;
            r.new_state     = (cmd == CMD_GETM) ? ST_I : ST_S;
          end
          ST_M: begin
            r.action        = ACT_BUS;
            r.assert_shared = 1'b1;
            r.new_state     = ST_I;
          end
          default: ;
        endcase
      end
      CMD_DATA: begin
        case (cur)
          ST_S, ST_E, ST_M: r.error_code = ERR_HELD_DATA;
          ST_IS: begin
            r.action    = ACT_PROC;
            r.new_state = shared ? ST_S : ST_E;
            r.peer_fill = shared;
          end
          ST_IM: begin
            r.action    = ACT_PROC;
            r.new_state = ST_M;
            r.peer_fill = shared;
          end
          ST_SM: begin
            r.action    = ACT_PROC;
            r.new_state = ST_M;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (r.action != ACT_NONE) r.out_address = addr;
    if (r.action == ACT_BUS) r.dest_id = src;
    line_model[idx] = r.new_state;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
      error_count++;
    end
  endfunction

  // Compare each result strobe with the oldest expected response
  always @(posedge clk_i) begin : result_check
    resp_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_responses.size() == 0) begin
        $error("result strobe with no response expected");
        error_count++;
      end else begin
        exp_r = pending_responses.pop_front();
        check_field("action", exp_r.action, action_o);
        check_field("assert_shared", exp_r.assert_shared, assert_shared_o);
        check_field("out_address", exp_r.out_address, out_address_o);
        check_field("dest_id", exp_r.dest_id, dest_id_o);
        check_field("new_state", exp_r.new_state, new_state_o);
        check_field("miss", exp_r.miss, miss_o);
        check_field("peer_fill", exp_r.peer_fill, peer_fill_o);
        check_field("error_code", exp_r.error_code, error_code_o);
        checked_count++;
        miss_count         += exp_r.miss;
        fill_count         += exp_r.peer_fill;
        bus_count          += (exp_r.action == ACT_BUS);
        protocol_err_count += (exp_r.error_code != ERR_NONE);
      end
    end
  end

  // Drive one event, hold it until the transfer, then record its expected response
  task automatic send_event(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic [ADDR_W-1:0] addr, logic [ID_W-1:0] src, logic shared);
    // while idling is on, drop start at random so that about IDLE_PCT percent of the time is idle
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start         <= 1'b1;
    command_i     <= cmd;
    line_index_i  <= idx;
    address_i     <= addr;
    source_id_i   <= src;
    shared_seen_i <= shared;
    do @(posedge clk_i); while (busy);
    pending_responses.push_back(next_line_response(cmd, idx, addr, src, shared));
    sent_count++;
  endtask

  // Hold off new events until every outstanding response has come back
  task automatic wait_for_responses();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk_i);
  endtask

  // Load miss, store while outstanding, clean fill, held-data error, silent upgrade, hit, snooped GETS on M
  task automatic test_load_fill_path();
    send_event(CMD_LOAD,  '0, '0, '0, 1'b0);
    send_event(CMD_STORE, '0, '0, '0, 1'b0);
    send_event(CMD_DATA,  '0, '0, '0, 1'b0);
    send_event(CMD_DATA,  '0, '0, '0, 1'b0);
    send_event(CMD_STORE, '0, 32'h0000_0040, '0, 1'b0);
    send_event(CMD_LOAD,  '0, 32'h0000_0040, '0, 1'b0);
    send_event(CMD_GETS,  '0, '1, '1, 1'b1);
  endtask

  // Store miss, snoop ignored in a transient state, fill from a peer, GETM steals M, stray data on I
  task automatic test_store_miss_peer_fill();
    send_event(CMD_STORE, '1, '1, '1, 1'b1);
    send_event(CMD_GETS,  '1, '1, '1, 1'b1);
    send_event(CMD_DATA,  '1, '1, '1, 1'b1);
    send_event(CMD_GETM,  '1, '1, '0, 1'b0);
    send_event(CMD_DATA,  '1, '1, '1, 1'b1);
  endtask

  // Shared fill, shared hit and supply, held-data error, upgrade from S through SM with a stray load and snoop
  task automatic test_shared_upgrade();
    send_event(CMD_LOAD,  10'd1, 32'hA5A5_5A5A, 4'd3, 1'b0);
    send_event(CMD_DATA,  10'd1, 32'hA5A5_5A5A, 4'd3, 1'b1);
    send_event(CMD_LOAD,  10'd1, 32'hA5A5_5A5A, 4'd3, 1'b0);
    send_event(CMD_GETS,  10'd1, 32'h5A5A_A5A5, 4'd5, 1'b0);
    send_event(CMD_DATA,  10'd1, 32'h5A5A_A5A5, 4'd5, 1'b0);
    send_event(CMD_STORE, 10'd1, 32'hA5A5_5A5A, 4'd3, 1'b0);
    send_event(CMD_LOAD,  10'd1, 32'hA5A5_5A5A, 4'd3, 1'b0);
    send_event(CMD_GETM,  10'd1, 32'h1234_5678, 4'd9, 1'b0);
    send_event(CMD_DATA,  10'd1, 32'hA5A5_5A5A, 4'd3, 1'b1);
  endtask

  // Exclusive line downgraded by GETS, then invalidated while shared
  task automatic test_exclusive_snoops();
    send_event(CMD_LOAD, 10'd2, 32'h8000_0000, 4'd0, 1'b0);
    send_event(CMD_DATA, 10'd2, 32'h8000_0000, 4'd0, 1'b0);
    send_event(CMD_GETS, 10'd2, 32'h8000_0000, 4'd12, 1'b0);
    send_event(CMD_GETM, 10'd2, 32'h8000_0000, 4'd7, 1'b0);
  endtask

  // Undefined commands leave the line alone, here on a line held in M
  task automatic test_unknown_commands();
    for (int c = int'(CMD_DATA) + 1; c < (1 << CMD_W); c++)
      send_event(CMD_W'(c), 10'd1, 32'h5A5A_A5A5, 4'd10, 1'b1);
  endtask

  // Mostly coherent traffic on a few hot lines, with noise and stray events mixed in
  task automatic test_random_traffic(int count, bit with_idles);
    logic [IDX_W-1:0] idx;
    logic [CMD_W-1:0] cmd;
    int               roll;
    idling_on = with_idles;
    for (int i = 0; i < count; i++) begin
      idx  = ($urandom_range(99) < 75) ? hot_lines[$urandom_range(HOT_LINES - 1)]
                                       : IDX_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 5)
        cmd = CMD_W'($urandom_range((1 << CMD_W) - 1, int'(CMD_DATA) + 1));
      else if (line_model[idx] inside {ST_IS, ST_IM, ST_SM} && $urandom_range(99) < 65)
        cmd = CMD_DATA;
      else if (roll < 45)
        cmd = $urandom_range(1) ? CMD_STORE : CMD_LOAD;
      else if (roll < 72)
        cmd = $urandom_range(1) ? CMD_GETM : CMD_GETS;
      else
        cmd = CMD_DATA;
      send_event(cmd, idx, $urandom, ID_W'($urandom_range(15)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = CMD_LOAD;
    line_index_i  = '0;
    address_i     = '0;
    source_id_i   = '0;
    shared_seen_i = 1'b0;
    idling_on     = 1'b1;
    foreach (line_model[i]) line_model[i] = ST_I;
    hot_lines[0] = '0;
    hot_lines[1] = '1;
    for (int i = 2; i < HOT_LINES; i++) hot_lines[i] = IDX_W'($urandom);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_load_fill_path();
    test_store_miss_peer_fill();
    test_shared_upgrade();
    test_exclusive_snoops();
    test_unknown_commands();
    test_random_traffic(150, 1'b0);
    test_random_traffic(225, 1'b1);
    wait_for_responses();
    test_random_traffic(225, 1'b1);

    // Drain, then keep waiting for stray strobes from the pipeline
    wait_for_responses();
    repeat (6) @(negedge clk_i);

    $display("Sent %0d events, checked %0d responses: %0d misses, %0d peer fills,",
             sent_count, checked_count, miss_count, fill_count);
    $display("%0d bus supplies and %0d protocol errors across directed and random traffic.",
             bus_count, protocol_err_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Timeout with %0d responses outstanding", pending_responses.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
